>>> design/touch_press_qualify_and_calibrate_defines.svh
// Shared assertion macros for the touch press block checkers.
// Each macro is evaluated on the rising clock edge and is disabled while
// the active-low reset is asserted.
`ifndef TOUCH_PRESS_QUALIFY_AND_CALIBRATE_DEFINES_SVH
`define TOUCH_PRESS_QUALIFY_AND_CALIBRATE_DEFINES_SVH

// Same-cycle implication.
`define TPQC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("touch press checker: same-cycle property failed");

// Next-cycle implication.
`define TPQC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("touch press checker: next-cycle property failed");

`endif

>>> design/tpqc_pkg.sv
`timescale 1ns / 1ps

package tpqc_pkg;

	// Fixed-point scale of the calibration coefficients.
	localparam longint unsigned SCALE_DIVISOR = 64'd10000;
	// Data event count that must be passed before a further data event qualifies a press.
	localparam int PRESS_THRESHOLD = 5;
	// Significant bits of the raw converter samples.
	localparam int SAMPLE_BITS = 12;

	localparam int RAW_W      = 12;
	localparam int POINT_W    = 16;
	localparam int GAIN_W     = 24;
	localparam int OFFSET_W   = 28;
	localparam int LIMIT_W    = 12;
	localparam int COUNT_W    = 3;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 28;

	// Product of a signed gain and a zero-extended raw sample, and the sum of two such
	// products plus an offset.
	localparam int MUL_W = GAIN_W + RAW_W + 1;
	localparam int ACC_W = MUL_W + 1;

	// Any magnitude at or above this saturates the 16-bit result.
	localparam longint unsigned SAT_MAG = (64'd1 << (POINT_W - 1)) * SCALE_DIVISOR;
	localparam int MAG_W    = $clog2(SAT_MAG);
	localparam int DIV_BITS = $clog2(SCALE_DIVISOR);

	// Reciprocal multiply: floor(n / D) == (n * RECIP_MUL) >> RECIP_SHIFT for every
	// n below 2**MAG_W, since the rounding error of the reciprocal stays below D.
	localparam int RECIP_SHIFT = MAG_W + DIV_BITS;
	localparam int RECIP_W     = MAG_W + 1;
	localparam int QPROD_W     = MAG_W + RECIP_W;
	localparam int QUOT_W      = POINT_W - 1;
	localparam logic [RECIP_W-1:0] RECIP_MUL =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + SCALE_DIVISOR - 64'd1) / SCALE_DIVISOR);

	localparam logic [RAW_W-1:0] SAMPLE_MASK = RAW_W'((64'd1 << SAMPLE_BITS) - 64'd1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_XX,
		REG_GAIN_XY,
		REG_OFFSET_X,
		REG_GAIN_YX,
		REG_GAIN_YY,
		REG_OFFSET_Y,
		REG_SCREEN_WIDTH,
		REG_SCREEN_HEIGHT
	} cfg_reg_t;

	typedef struct packed {
		logic             data_ready;
		logic             lift;
		logic [RAW_W-1:0] raw_x;
		logic [RAW_W-1:0] raw_y;
	} status_t;

	typedef struct packed {
		logic                      pressed;
		logic signed [POINT_W-1:0] point_x;
		logic signed [POINT_W-1:0] point_y;
		logic                      in_range;
	} point_t;

	// Press state after the most recent status transaction.
	typedef struct packed {
		logic             pressed;
		logic [RAW_W-1:0] x;
		logic [RAW_W-1:0] y;
	} qual_t;

	// Load enables of the calibration stages.
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
	} pipe_en_t;

endpackage

>>> design/tpqc_qualify.sv
`timescale 1ns / 1ps

// Press qualifier: keeps the raw point, the sample counter and the pressed flag.
module tpqc_qualify (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  tpqc_pkg::status_t    status,
	output tpqc_pkg::qual_t      qual
);

	logic [tpqc_pkg::RAW_W-1:0]   stored_x_q;
	logic [tpqc_pkg::RAW_W-1:0]   stored_y_q;
	logic [tpqc_pkg::COUNT_W-1:0] count_q;
	logic                         held_q;

	logic [tpqc_pkg::COUNT_W-1:0] count_d;
	logic                         held_d;

	always_comb begin
		count_d = count_q;
		held_d  = held_q;
		if (status.data_ready) begin
			if (count_q > tpqc_pkg::COUNT_W'(tpqc_pkg::PRESS_THRESHOLD)) begin
				held_d = 1'b1;
			end else begin
				count_d = count_q + 1'b1;
			end
		end
		// For the flag and count, a lift wins over data carried by the same transaction.
		if (status.lift) begin
			held_d  = 1'b0;
			count_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_x_q <= '0;
			stored_y_q <= '0;
			count_q    <= '0;
			held_q     <= 1'b0;
		end else if (accept) begin
			count_q <= count_d;
			held_q  <= held_d;
			if (status.data_ready) begin
				stored_x_q <= status.raw_x & tpqc_pkg::SAMPLE_MASK;
				stored_y_q <= status.raw_y & tpqc_pkg::SAMPLE_MASK;
			end
		end
	end

	assign qual.pressed = held_q;
	assign qual.x       = stored_x_q;
	assign qual.y       = stored_y_q;

endmodule

>>> design/tpqc_axis.sv
`timescale 1ns / 1ps

// One calibrated axis: gain_a * x + gain_b * y + offset, divided by the scale
// with truncation toward zero and saturated to 16 bits.
module tpqc_axis (
	input  logic                                 clk,
	input  tpqc_pkg::pipe_en_t                   en,
	input  logic [tpqc_pkg::RAW_W-1:0]           raw_x,
	input  logic [tpqc_pkg::RAW_W-1:0]           raw_y,
	input  logic signed [tpqc_pkg::GAIN_W-1:0]   gain_a,
	input  logic signed [tpqc_pkg::GAIN_W-1:0]   gain_b,
	input  logic signed [tpqc_pkg::OFFSET_W-1:0] offset,
	output logic signed [tpqc_pkg::POINT_W-1:0]  value
);

	logic signed [tpqc_pkg::MUL_W-1:0]   prod_a_s2;
	logic signed [tpqc_pkg::MUL_W-1:0]   prod_b_s2;
	logic signed [tpqc_pkg::OFFSET_W-1:0] offset_s2;

	logic                                sign_s3;
	logic                                sat_s3;
	logic [tpqc_pkg::MAG_W-1:0]          mag_s3;

	logic                                sign_s4;
	logic                                sat_s4;
	logic [tpqc_pkg::QPROD_W-1:0]        qprod_s4;

	logic signed [tpqc_pkg::ACC_W-1:0]   acc;
	logic [tpqc_pkg::ACC_W-1:0]          acc_abs;
	logic [tpqc_pkg::QUOT_W-1:0]         quot;
	logic signed [tpqc_pkg::POINT_W-1:0] quot_s;

	always_ff @(posedge clk) begin
		if (en.ld_s2) begin
			prod_a_s2 <= gain_a * $signed({1'b0, raw_x});
			prod_b_s2 <= gain_b * $signed({1'b0, raw_y});
			offset_s2 <= offset;
		end
	end

	always_comb begin
		acc = tpqc_pkg::ACC_W'(prod_a_s2) + tpqc_pkg::ACC_W'(prod_b_s2)
			+ tpqc_pkg::ACC_W'(offset_s2);
		acc_abs = acc[tpqc_pkg::ACC_W-1] ? -acc : acc;
	end

	always_ff @(posedge clk) begin
		if (en.ld_s3) begin
			sign_s3 <= acc[tpqc_pkg::ACC_W-1];
			sat_s3  <= acc_abs >= tpqc_pkg::ACC_W'(tpqc_pkg::SAT_MAG);
			mag_s3  <= acc_abs[tpqc_pkg::MAG_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en.ld_s4) begin
			sign_s4  <= sign_s3;
			sat_s4   <= sat_s3;
			qprod_s4 <= tpqc_pkg::QPROD_W'(mag_s3) * tpqc_pkg::QPROD_W'(tpqc_pkg::RECIP_MUL);
		end
	end

	always_comb begin
		quot   = qprod_s4[tpqc_pkg::RECIP_SHIFT +: tpqc_pkg::QUOT_W];
		quot_s = $signed({1'b0, quot});
		if (sat_s4) begin
			value = sign_s4 ? {1'b1, {(tpqc_pkg::POINT_W-1){1'b0}}}
				: {1'b0, {(tpqc_pkg::POINT_W-1){1'b1}}};
		end else begin
			value = sign_s4 ? -quot_s : quot_s;
		end
	end

endmodule

>>> design/touch_press_qualify_and_calibrate.sv
`timescale 1ns / 1ps

// Touch press qualifier with affine calibration.
// The status channel (status_valid / status_ready / status) takes one controller
// event per transaction. Data events store the raw point and count up; once the
// count has passed the press threshold, a further data event sets the pressed flag.
// A lift event clears flag and count. Every status transaction yields exactly one
// transaction on the point channel (point_valid / point_ready / point), in order.
// From the accepting edge of a status transaction to point_valid, the item is taken
// into the press state register and then passes the two gain multipliers, the sum
// and saturation check and the reciprocal multiply for the constant divide before it
// lands in the output register.
// Unstalled, throughput is one transaction per cycle; each stage moves on as it loads.
// When the receiver stalls, items close up behind the output register, so status_ready
// stays high until every stage holds an item; it then follows point_ready.
// The configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data) is always
// ready; writes to an index beyond the register list are dropped.
// Reset clears the press state, the held point and all valid flags and loads the
// default calibration; the block accepts transactions in the first cycle after reset.
module touch_press_qualify_and_calibrate (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              status_valid,
	output logic                              status_ready,
	input  tpqc_pkg::status_t                 status,
	output logic                              point_valid,
	input  logic                              point_ready,
	output tpqc_pkg::point_t                  point,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tpqc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tpqc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	// Calibration registers.
	logic signed [tpqc_pkg::GAIN_W-1:0]   gain_xx_q;
	logic signed [tpqc_pkg::GAIN_W-1:0]   gain_xy_q;
	logic signed [tpqc_pkg::OFFSET_W-1:0] offset_x_q;
	logic signed [tpqc_pkg::GAIN_W-1:0]   gain_yx_q;
	logic signed [tpqc_pkg::GAIN_W-1:0]   gain_yy_q;
	logic signed [tpqc_pkg::OFFSET_W-1:0] offset_y_q;
	logic [tpqc_pkg::LIMIT_W-1:0]         screen_width_q;
	logic [tpqc_pkg::LIMIT_W-1:0]         screen_height_q;

	// Pipeline occupancy and the pressed flag that rides along with each item.
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic pressed_s2, pressed_s3, pressed_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_out;
	logic accept;

	// Output register and the held calibrated point.
	logic                                point_valid_q;
	logic                                pressed_q;
	logic                                in_range_q;
	logic signed [tpqc_pkg::POINT_W-1:0] held_x_q;
	logic signed [tpqc_pkg::POINT_W-1:0] held_y_q;

	tpqc_pkg::qual_t                     qual;
	tpqc_pkg::pipe_en_t                  en;
	logic signed [tpqc_pkg::POINT_W-1:0] cal_x;
	logic signed [tpqc_pkg::POINT_W-1:0] cal_y;
	logic                                cal_in_range;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_xx_q       <= -tpqc_pkg::GAIN_W'(4590);
			gain_xy_q       <= tpqc_pkg::GAIN_W'(2783);
			offset_x_q      <= tpqc_pkg::OFFSET_W'(8517532);
			gain_yx_q       <= tpqc_pkg::GAIN_W'(453);
			gain_yy_q       <= -tpqc_pkg::GAIN_W'(6556);
			offset_y_q      <= tpqc_pkg::OFFSET_W'(5014778);
			screen_width_q  <= tpqc_pkg::LIMIT_W'(800);
			screen_height_q <= tpqc_pkg::LIMIT_W'(480);
		end else if (cfg_valid) begin
			unique case (tpqc_pkg::cfg_reg_t'(cfg_index))
				tpqc_pkg::REG_GAIN_XX:       gain_xx_q       <= cfg_data[tpqc_pkg::GAIN_W-1:0];
				tpqc_pkg::REG_GAIN_XY:       gain_xy_q       <= cfg_data[tpqc_pkg::GAIN_W-1:0];
				tpqc_pkg::REG_OFFSET_X:      offset_x_q      <= cfg_data[tpqc_pkg::OFFSET_W-1:0];
				tpqc_pkg::REG_GAIN_YX:       gain_yx_q       <= cfg_data[tpqc_pkg::GAIN_W-1:0];
				tpqc_pkg::REG_GAIN_YY:       gain_yy_q       <= cfg_data[tpqc_pkg::GAIN_W-1:0];
				tpqc_pkg::REG_OFFSET_Y:      offset_y_q      <= cfg_data[tpqc_pkg::OFFSET_W-1:0];
				tpqc_pkg::REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data[tpqc_pkg::LIMIT_W-1:0];
				tpqc_pkg::REG_SCREEN_HEIGHT: screen_height_q <= cfg_data[tpqc_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Each stage can take a new item when it is empty or its item moves on. Bubbles
	// therefore close up while the output waits.
	assign rdy_out      = !point_valid_q || point_ready;
	assign rdy_s4       = !valid_s4 || rdy_out;
	assign rdy_s3       = !valid_s3 || rdy_s4;
	assign rdy_s2       = !valid_s2 || rdy_s3;
	assign rdy_s1       = !valid_s1 || rdy_s2;
	assign status_ready = rdy_s1;
	assign accept       = status_valid && rdy_s1;

	assign en.ld_s2 = valid_s1 && rdy_s2;
	assign en.ld_s3 = valid_s2 && rdy_s3;
	assign en.ld_s4 = valid_s3 && rdy_s4;

	// The press state registers double as the first stage: they change only when a
	// transaction is accepted, which is also when the first stage takes a new item.
	tpqc_qualify u_qualify (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.status (status),
		.qual   (qual)
	);

	tpqc_axis u_axis_x (
		.clk    (clk),
		.en     (en),
		.raw_x  (qual.x),
		.raw_y  (qual.y),
		.gain_a (gain_xx_q),
		.gain_b (gain_xy_q),
		.offset (offset_x_q),
		.value  (cal_x)
	);

	tpqc_axis u_axis_y (
		.clk    (clk),
		.en     (en),
		.raw_x  (qual.x),
		.raw_y  (qual.y),
		.gain_a (gain_yx_q),
		.gain_b (gain_yy_q),
		.offset (offset_y_q),
		.value  (cal_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			valid_s3      <= 1'b0;
			valid_s4      <= 1'b0;
			point_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) begin
				valid_s1 <= status_valid;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy_s3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy_s4) begin
				valid_s4 <= valid_s3;
			end
			if (rdy_out) begin
				point_valid_q <= valid_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.ld_s2) begin
			pressed_s2 <= qual.pressed;
		end
		if (en.ld_s3) begin
			pressed_s3 <= pressed_s2;
		end
		if (en.ld_s4) begin
			pressed_s4 <= pressed_s3;
		end
	end

	// A pressed point counts as on screen when both coordinates are non-negative and below
	// their limits; a zero limit therefore admits nothing.
	assign cal_in_range = pressed_s4
		&& !cal_x[tpqc_pkg::POINT_W-1] && !cal_y[tpqc_pkg::POINT_W-1]
		&& (cal_x[tpqc_pkg::POINT_W-2:0] < (tpqc_pkg::POINT_W-1)'(screen_width_q))
		&& (cal_y[tpqc_pkg::POINT_W-2:0] < (tpqc_pkg::POINT_W-1)'(screen_height_q));

	// The held point only moves with a pressed item; otherwise the last one repeats.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_x_q <= '0;
			held_y_q <= '0;
		end else if (valid_s4 && rdy_out && pressed_s4) begin
			held_x_q <= cal_x;
			held_y_q <= cal_y;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s4 && rdy_out) begin
			pressed_q  <= pressed_s4;
			in_range_q <= cal_in_range;
		end
	end

	assign point_valid    = point_valid_q;
	assign point.pressed  = pressed_q;
	assign point.point_x  = held_x_q;
	assign point.point_y  = held_y_q;
	assign point.in_range = in_range_q;

endmodule

>>> design/tpqc_checker.sv
`timescale 1ns / 1ps
`include "touch_press_qualify_and_calibrate_defines.svh"

// Port-level checks for the touch press block.
module tpqc_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             status_ready,
	input logic             point_valid,
	input logic             point_ready,
	input tpqc_pkg::point_t point
);

	// An on-screen report always belongs to a qualified press.
	`TPQC_ASSERT_NOW(a_range_needs_press, clk, arst_n, point_valid && point.in_range, point.pressed)

	// An on-screen point has non-negative coordinates.
	`TPQC_ASSERT_NOW(a_range_nonneg, clk, arst_n, point_valid && point.in_range, !point.point_x[15] && !point.point_y[15])

	// With the output register empty, nothing can hold back the status channel.
	`TPQC_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !point_valid, status_ready)

	// A stalled point transaction keeps its payload.
	`TPQC_ASSERT_NEXT(a_point_hold, clk, arst_n, point_valid && !point_ready, point_valid && $stable(point))

endmodule

bind touch_press_qualify_and_calibrate tpqc_checker u_tpqc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.status_ready (status_ready),
	.point_valid  (point_valid),
	.point_ready  (point_ready),
	.point        (point)
);
